>>> rtl/fbba_pkg.sv
// Shared types and constants for the free-block bitmap allocator.
package fbba_pkg;

   localparam int MAP_WORDS_DEFAULT = 16;
   localparam int MAX_LIVE_WORDS    = 16;
   localparam int WORD_BITS         = 32;
   localparam int BIT_IDX_W         = 5;
   localparam int BLOCK_W           = 9;
   localparam int WORD_IDX_W        = 4;
   localparam logic [WORD_BITS-1:0] FULL_WORD = 32'hffff_ffff;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_LOAD  = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_NOT_OPEN = 2'd1,
      STAT_FULL     = 2'd2,
      STAT_RANGE    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_CLEAR,
      S_FETCH,
      S_REPLY
   } state_type;

   typedef struct packed {
      logic                 found;
      logic [BIT_IDX_W-1:0] bit_idx;
   } find_result_type;

endpackage

>>> rtl/free_block_bitmap_allocator_unit.sv
// Allocate (one word scanned per cycle), free and read use the scan, clear and fetch states;
// load, not-open and out-of-range requests go straight to reply. One request is in work at a
// time; the scan of up to LIVE_WORDS words through the single zero finder sets the rate.
// A new request is taken while the previous word still waits at the response output.
// Synchronous reset clears fs_open and marks every bitmap word free at once.
// Top level of the free-block bitmap allocator.
module free_block_bitmap_allocator_unit #(
   parameter int MAP_WORDS = fbba_pkg::MAP_WORDS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_operation,
   input  logic [fbba_pkg::BLOCK_W-1:0]    req_block_number,
   input  logic [fbba_pkg::WORD_IDX_W-1:0] req_word_index,
   input  logic [fbba_pkg::WORD_BITS-1:0]  req_word_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_status,
   output logic [fbba_pkg::BLOCK_W-1:0]    rsp_allocated_block,
   output logic [fbba_pkg::WORD_BITS-1:0]  rsp_word_value,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic                            csr_fs_open
);

   localparam int LIVE_WORDS  = (MAP_WORDS < fbba_pkg::MAX_LIVE_WORDS) ?
                                MAP_WORDS : fbba_pkg::MAX_LIVE_WORDS;
   localparam int WA_W        = (LIVE_WORDS > 1) ? $clog2(LIVE_WORDS) : 1;
   localparam int LIVE_BLOCKS = LIVE_WORDS * fbba_pkg::WORD_BITS;
   localparam logic [fbba_pkg::WORD_IDX_W:0] LIVE_WORDS_L =
      (fbba_pkg::WORD_IDX_W+1)'(LIVE_WORDS);
   localparam logic [fbba_pkg::BLOCK_W:0] LIVE_BLOCKS_L =
      (fbba_pkg::BLOCK_W+1)'(LIVE_BLOCKS);
   localparam logic [WA_W-1:0] LAST_WORD = WA_W'(LIVE_WORDS - 1);

   fbba_pkg::state_type  state_ff, state_in;
   logic                 fs_open_ff;
   logic [WA_W-1:0]      word_ptr_ff, word_ptr_in;
   logic [fbba_pkg::BIT_IDX_W-1:0] bit_ff, bit_in;

   fbba_pkg::status_type           res_status_ff, res_status_in;
   logic [fbba_pkg::BLOCK_W-1:0]   res_block_ff, res_block_in;
   logic [fbba_pkg::WORD_BITS-1:0] res_value_ff, res_value_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   fbba_pkg::status_type           rsp_status_ff;
   logic [fbba_pkg::BLOCK_W-1:0]   rsp_block_ff;
   logic [fbba_pkg::WORD_BITS-1:0] rsp_value_ff;

   logic                           accept;
   logic                           out_free;
   logic                           load_out;
   fbba_pkg::op_type               req_op;
   logic                           word_ok;
   logic                           block_ok;

   logic                           mem_wr_en;
   logic [WA_W-1:0]                mem_wr_addr;
   logic [fbba_pkg::WORD_BITS-1:0] mem_wr_data;
   logic [WA_W-1:0]                mem_rd_addr;
   logic [fbba_pkg::WORD_BITS-1:0] mem_rd_data;
   fbba_pkg::find_result_type      find;

   fbba_map_mem #(
      .DEPTH  (LIVE_WORDS),
      .ADDR_W (WA_W)
   ) u_map_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   fbba_zero_find u_zero_find (
      .word   (mem_rd_data),
      .result (find)
   );

   assign req_stall = (state_ff != fbba_pkg::S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign req_op    = fbba_pkg::op_type'(req_operation);
   assign word_ok   = ({1'b0, req_word_index} < LIVE_WORDS_L);
   assign block_ok  = ({1'b0, req_block_number} < LIVE_BLOCKS_L);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fbba_pkg::S_IDLE: begin
            if (accept) begin
               if (!fs_open_ff) begin
                  state_in = fbba_pkg::S_REPLY;
               end else begin
                  unique case (req_op)
                     fbba_pkg::OP_ALLOC: state_in = fbba_pkg::S_SCAN;
                     fbba_pkg::OP_FREE:
                        state_in = block_ok ? fbba_pkg::S_CLEAR : fbba_pkg::S_REPLY;
                     fbba_pkg::OP_LOAD:  state_in = fbba_pkg::S_REPLY;
                     fbba_pkg::OP_READ:
                        state_in = word_ok ? fbba_pkg::S_FETCH : fbba_pkg::S_REPLY;
                     default:            state_in = fbba_pkg::S_REPLY;
                  endcase
               end
            end
         end
         fbba_pkg::S_SCAN: begin
            if (find.found || (word_ptr_ff == LAST_WORD)) begin
               state_in = fbba_pkg::S_REPLY;
            end
         end
         fbba_pkg::S_CLEAR: state_in = fbba_pkg::S_REPLY;
         fbba_pkg::S_FETCH: state_in = fbba_pkg::S_REPLY;
         fbba_pkg::S_REPLY: begin
            if (out_free) begin
               state_in = fbba_pkg::S_IDLE;
            end
         end
         default: state_in = fbba_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      mem_wr_en     = 1'b0;
      mem_wr_addr   = word_ptr_ff;
      mem_wr_data   = mem_rd_data | (fbba_pkg::WORD_BITS'(1) << find.bit_idx);
      mem_rd_addr   = word_ptr_ff + WA_W'(1);
      word_ptr_in   = word_ptr_ff;
      bit_in        = bit_ff;
      res_status_in = res_status_ff;
      res_block_in  = res_block_ff;
      res_value_in  = res_value_ff;
      load_out      = 1'b0;
      unique case (state_ff)
         fbba_pkg::S_IDLE: begin
            res_status_in = fbba_pkg::STAT_OK;
            res_block_in  = '0;
            res_value_in  = '0;
            bit_in        = req_block_number[fbba_pkg::BIT_IDX_W-1:0];
            unique case (req_op)
               fbba_pkg::OP_ALLOC: mem_rd_addr = '0;
               fbba_pkg::OP_FREE:
                  mem_rd_addr = req_block_number[fbba_pkg::BIT_IDX_W +: WA_W];
               default:            mem_rd_addr = req_word_index[WA_W-1:0];
            endcase
            word_ptr_in = mem_rd_addr;
            if (!fs_open_ff) begin
               res_status_in = fbba_pkg::STAT_NOT_OPEN;
            end else begin
               unique case (req_op)
                  fbba_pkg::OP_ALLOC: ;
                  fbba_pkg::OP_FREE: begin
                     if (!block_ok) res_status_in = fbba_pkg::STAT_RANGE;
                  end
                  fbba_pkg::OP_LOAD: begin
                     if (word_ok) begin
                        mem_wr_en   = accept;
                        mem_wr_addr = req_word_index[WA_W-1:0];
                        mem_wr_data = req_word_data;
                     end else begin
                        res_status_in = fbba_pkg::STAT_RANGE;
                     end
                  end
                  fbba_pkg::OP_READ: begin
                     if (!word_ok) res_status_in = fbba_pkg::STAT_RANGE;
                  end
                  default: ;
               endcase
            end
         end
         fbba_pkg::S_SCAN: begin
            if (find.found) begin
               mem_wr_en    = 1'b1;
               res_block_in = fbba_pkg::BLOCK_W'({word_ptr_ff, find.bit_idx});
            end else if (word_ptr_ff == LAST_WORD) begin
               res_status_in = fbba_pkg::STAT_FULL;
            end else begin
               word_ptr_in = word_ptr_ff + WA_W'(1);
            end
         end
         fbba_pkg::S_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = mem_rd_data & ~(fbba_pkg::WORD_BITS'(1) << bit_ff);
         end
         fbba_pkg::S_FETCH: begin
            res_value_in = mem_rd_data;
         end
         fbba_pkg::S_REPLY: begin
            load_out = out_free;
         end
         default: ;
      endcase
   end

   // The response register keeps its word until the far side takes it.
   assign rsp_valid_in = load_out ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fbba_pkg::S_IDLE;
         fs_open_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            fs_open_ff <= csr_fs_open;
         end
      end
   end

   always_ff @(posedge clock) begin
      word_ptr_ff   <= word_ptr_in;
      bit_ff        <= bit_in;
      res_status_ff <= res_status_in;
      res_block_ff  <= res_block_in;
      res_value_ff  <= res_value_in;
      if (load_out) begin
         rsp_status_ff <= res_status_ff;
         rsp_block_ff  <= res_block_ff;
         rsp_value_ff  <= res_value_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_allocated_block = rsp_block_ff;
   assign rsp_word_value      = rsp_value_ff;

endmodule

>>> rtl/fbba_map_mem.sv
// Bitmap word memory with one write port, a registered read port and per-word valid bits.
module fbba_map_mem #(
   parameter int DEPTH  = fbba_pkg::MAX_LIVE_WORDS,
   parameter int ADDR_W = fbba_pkg::WORD_IDX_W
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [ADDR_W-1:0]              wr_addr,
   input  logic [fbba_pkg::WORD_BITS-1:0] wr_data,
   input  logic [ADDR_W-1:0]              rd_addr,
   output logic [fbba_pkg::WORD_BITS-1:0] rd_data
);

   logic [fbba_pkg::WORD_BITS-1:0] mem [DEPTH];
   logic [DEPTH-1:0]               valid_ff;
   logic [fbba_pkg::WORD_BITS-1:0] rd_data_ff;
   logic                           rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // A word never written since reset reads as all free.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

>>> rtl/fbba_zero_find.sv
// Finds the lowest clear bit of a bitmap word with a five-level halving tree.
module fbba_zero_find (
   input  logic [fbba_pkg::WORD_BITS-1:0] word,
   output fbba_pkg::find_result_type      result
);

   logic [31:0] free_bits;
   logic [15:0] half16;
   logic [7:0]  half8;
   logic [3:0]  half4;
   logic [1:0]  half2;
   logic [4:0]  idx;

   always_comb begin
      free_bits = ~word;
      idx[4] = (free_bits[15:0] == 16'd0);
      half16 = idx[4] ? free_bits[31:16] : free_bits[15:0];
      idx[3] = (half16[7:0] == 8'd0);
      half8  = idx[3] ? half16[15:8] : half16[7:0];
      idx[2] = (half8[3:0] == 4'd0);
      half4  = idx[2] ? half8[7:4] : half8[3:0];
      idx[1] = (half4[1:0] == 2'd0);
      half2  = idx[1] ? half4[3:2] : half4[1:0];
      idx[0] = ~half2[0];
      result.found   = (free_bits != 32'd0);
      result.bit_idx = idx;
   end

endmodule
